/* rtl/core/tmcw_pkg.sv */
// Shared types, constants and the control store for the text console writer.
`default_nettype none

package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int TAB_LAST_K = (COLUMNS - 1) / TAB_STOP + 1;

    // Internal widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWX_W = $clog2(ROWS + 1);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // Port widths
    localparam int LOC_OUT_W = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int LOCX_W    = (ADDR_W > LOC_OUT_W) ? ADDR_W : LOC_OUT_W;

    typedef logic [COL_W-1:0]     col_t;
    typedef logic [COLX_W-1:0]    colx_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [ROWX_W-1:0]    rowx_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [LOCX_W-1:0]    locx_t;
    typedef logic [LOC_OUT_W-1:0] loc_out_t;
    typedef logic [COL_OUT_W-1:0] col_out_t;
    typedef logic [ROW_OUT_W-1:0] row_out_t;
    typedef logic [15:0]          cell_t;

    // Cell contents and character codes
    localparam cell_t      BLANK_CELL     = 16'h0F20;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI  = 8'h7F;

    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Sequencer steps
    typedef enum logic [3:0] {
        STEP_IDLE        = 4'd0,
        STEP_CLEAR_INIT  = 4'd1,
        STEP_CLEAR_LOOP  = 4'd2,
        STEP_PUT         = 4'd3,
        STEP_SCROLL_INIT = 4'd4,
        STEP_SCROLL_RD   = 4'd5,
        STEP_SCROLL_WR   = 4'd6,
        STEP_BLANK_ROW   = 4'd7
    } step_t;

    typedef enum logic [1:0] {
        WE_NONE,
        WE_ALWAYS,
        WE_PRINTABLE
    } we_mode_t;

    typedef enum logic [1:0] {
        WSRC_BLANK,
        WSRC_CHAR,
        WSRC_COPY
    } wsrc_t;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_INC
    } addr_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_PUT
    } cur_op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_ROW_OVF,
        COND_NOT_LAST_CELL,
        COND_NOT_COPY_END
    } cond_t;

    // One control word: datapath actions, branch condition, taken target and
    // fall-through step, and whether the fall-through path reports a result.
    typedef struct packed {
        we_mode_t we_mode;
        wsrc_t    wsrc;
        logic     mem_rd;
        addr_op_t addr_op;
        cur_op_t  cur_op;
        cond_t    cond;
        step_t    target;
        step_t    fall;
        logic     report_on_fall;
    } ctrl_t;

    function automatic ctrl_t microcode(step_t step);
        ctrl_t cw;
        cw = '{we_mode: WE_NONE, wsrc: WSRC_BLANK, mem_rd: 1'b0, addr_op: ADDR_HOLD,
               cur_op: CUR_HOLD, cond: COND_ALWAYS, target: STEP_IDLE,
               fall: STEP_IDLE, report_on_fall: 1'b0};
        unique case (step)
            STEP_IDLE:
            begin
                cw.cond   = COND_DISPATCH;
                cw.target = STEP_CLEAR_INIT;
                cw.fall   = STEP_PUT;
            end
            STEP_CLEAR_INIT:
            begin
                cw.addr_op = ADDR_ZERO;
                cw.cur_op  = CUR_HOME;
                cw.fall    = STEP_CLEAR_LOOP;
            end
            STEP_CLEAR_LOOP:
            begin
                cw.we_mode        = WE_ALWAYS;
                cw.wsrc           = WSRC_BLANK;
                cw.addr_op        = ADDR_INC;
                cw.cond           = COND_NOT_LAST_CELL;
                cw.target         = STEP_CLEAR_LOOP;
                cw.fall           = STEP_IDLE;
                cw.report_on_fall = 1'b1;
            end
            STEP_PUT:
            begin
                cw.we_mode        = WE_PRINTABLE;
                cw.wsrc           = WSRC_CHAR;
                cw.cur_op         = CUR_PUT;
                cw.cond           = COND_ROW_OVF;
                cw.target         = STEP_SCROLL_INIT;
                cw.fall           = STEP_IDLE;
                cw.report_on_fall = 1'b1;
            end
            STEP_SCROLL_INIT:
            begin
                cw.addr_op = ADDR_ZERO;
                cw.fall    = STEP_SCROLL_RD;
            end
            STEP_SCROLL_RD:
            begin
                cw.mem_rd = 1'b1;
                cw.fall   = STEP_SCROLL_WR;
            end
            STEP_SCROLL_WR:
            begin
                cw.we_mode = WE_ALWAYS;
                cw.wsrc    = WSRC_COPY;
                cw.addr_op = ADDR_INC;
                cw.cond    = COND_NOT_COPY_END;
                cw.target  = STEP_SCROLL_RD;
                cw.fall    = STEP_BLANK_ROW;
            end
            STEP_BLANK_ROW:
            begin
                cw.we_mode        = WE_ALWAYS;
                cw.wsrc           = WSRC_BLANK;
                cw.addr_op        = ADDR_INC;
                cw.cond           = COND_NOT_LAST_CELL;
                cw.target         = STEP_BLANK_ROW;
                cw.fall           = STEP_IDLE;
                cw.report_on_fall = 1'b1;
            end
            default:
            begin
                cw.fall = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

    // Next tab stop strictly above the given column.
    function automatic colx_t tab_next(col_t col);
        colx_t r;
        r = colx_t'(TAB_LAST_K * TAB_STOP);
        for (int k = TAB_LAST_K; k >= 1; k--)
        begin
            if (k * TAB_STOP > int'(col))
            begin
                r = colx_t'(k * TAB_STOP);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/text_mode_console_writer.sv */
// Text console writer: microcoded sequencer over a cell store and a cursor.
// A put without scroll passes through STEP_PUT and the valid register before its result
// shows on valid, and start is taken again in the valid cycle.
// A scroll adds STEP_SCROLL_INIT, a copy loop of (ROWS-1)*COLUMNS cells that alternates
// STEP_SCROLL_RD and STEP_SCROLL_WR for each cell, then STEP_BLANK_ROW over the last row.
// A clear holds busy through STEP_CLEAR_INIT and STEP_CLEAR_LOOP over all COLUMNS*ROWS cells.
// After rst_n the store is cleared while busy stays high, and no result is reported.
`default_nettype none

module text_mode_console_writer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [7:0]  char_code,
    input  wire logic [3:0]  background_color,
    input  wire logic [3:0]  foreground_color,
    output logic             valid,
    output logic [10:0]      cursor_location,
    output logic [6:0]       cursor_column,
    output logic [4:0]       cursor_row,
    output logic             scrolled
);

    // Sequencer state
    tmcw_pkg::step_t    step_reg, step_next;
    tmcw_pkg::ctrl_t    cw;

    // Datapath registers
    tmcw_pkg::addr_t    addr_reg, addr_next;
    tmcw_pkg::col_t     col_reg, col_next;
    tmcw_pkg::row_t     row_reg, row_next;
    logic               scroll_reg, scroll_next;
    logic               pending_reg, pending_next;
    logic               op_reg, op_next;
    logic [7:0]         char_reg, char_next;
    logic [7:0]         attr_reg, attr_next;

    // Result registers
    logic               valid_reg, valid_next;
    tmcw_pkg::loc_out_t loc_reg, loc_next;
    tmcw_pkg::col_out_t ccol_reg, ccol_next;
    tmcw_pkg::row_out_t crow_reg, crow_next;
    logic               scr_reg, scr_next;

    // Cell store
    tmcw_pkg::cell_t    mem [tmcw_pkg::CELL_COUNT];
    tmcw_pkg::cell_t    rdata_reg;
    logic               mem_we;
    tmcw_pkg::addr_t    mem_waddr;
    tmcw_pkg::cell_t    mem_wdata;
    tmcw_pkg::addr_t    mem_raddr;

    // Put datapath
    tmcw_pkg::colx_t    put_col;
    tmcw_pkg::rowx_t    put_row;
    logic               printable;
    logic               row_ovf;
    tmcw_pkg::addr_t    cursor_idx;
    tmcw_pkg::locx_t    loc_full;
    logic               accept;
    logic               taken;

    assign busy   = (step_reg != tmcw_pkg::STEP_IDLE);
    assign accept = start && !busy;
    assign cw     = tmcw_pkg::microcode(step_reg);

    // Work out where the cursor goes for the latched character.
    always_comb
    begin
        put_col   = tmcw_pkg::colx_t'(col_reg);
        put_row   = tmcw_pkg::rowx_t'(row_reg);
        printable = (char_reg >= tmcw_pkg::CHAR_PRINT_LO)
                 && (char_reg <= tmcw_pkg::CHAR_PRINT_HI);
        priority if (char_reg == tmcw_pkg::CHAR_BACKSPACE)
        begin
            if (col_reg != '0)
            begin
                put_col = tmcw_pkg::colx_t'(col_reg) - tmcw_pkg::colx_t'(1);
            end
        end
        else if (char_reg == tmcw_pkg::CHAR_TAB)
        begin
            put_col = tmcw_pkg::tab_next(col_reg);
        end
        else if (char_reg == tmcw_pkg::CHAR_CR)
        begin
            put_col = '0;
        end
        else if (char_reg == tmcw_pkg::CHAR_LF)
        begin
            put_col = '0;
            put_row = put_row + tmcw_pkg::rowx_t'(1);
        end
        else if (printable)
        begin
            put_col = put_col + tmcw_pkg::colx_t'(1);
        end
        else
        begin
            put_col = tmcw_pkg::colx_t'(col_reg);
        end
        // Wrap past the right edge onto the next row.
        if (put_col >= tmcw_pkg::colx_t'(tmcw_pkg::COLUMNS))
        begin
            put_col = '0;
            put_row = put_row + tmcw_pkg::rowx_t'(1);
        end
        row_ovf = (put_row >= tmcw_pkg::rowx_t'(tmcw_pkg::ROWS));
    end

    assign cursor_idx = tmcw_pkg::addr_t'(row_reg) * tmcw_pkg::addr_t'(tmcw_pkg::COLUMNS)
                      + tmcw_pkg::addr_t'(col_reg);

    // Store port selection
    always_comb
    begin
        unique case (cw.we_mode)
            tmcw_pkg::WE_ALWAYS:    mem_we = 1'b1;
            tmcw_pkg::WE_PRINTABLE: mem_we = printable;
            default:                mem_we = 1'b0;
        endcase
        unique case (cw.wsrc)
            tmcw_pkg::WSRC_CHAR:  mem_wdata = {attr_reg, char_reg};
            tmcw_pkg::WSRC_COPY:  mem_wdata = rdata_reg;
            default:              mem_wdata = tmcw_pkg::BLANK_CELL;
        endcase
        mem_waddr = (cw.wsrc == tmcw_pkg::WSRC_CHAR) ? cursor_idx : addr_reg;
        mem_raddr = addr_reg + tmcw_pkg::addr_t'(tmcw_pkg::COLUMNS);
    end

    // Sequencer and datapath next state
    always_comb
    begin
        step_next    = step_reg;
        addr_next    = addr_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        scroll_next  = scroll_reg;
        pending_next = pending_reg;
        op_next      = op_reg;
        char_next    = char_reg;
        attr_next    = attr_reg;
        valid_next   = 1'b0;
        taken        = 1'b0;

        // Latch the transaction and drop the old scroll mark.
        if (accept)
        begin
            op_next      = operation;
            char_next    = char_code;
            attr_next    = {background_color, foreground_color};
            pending_next = 1'b1;
            scroll_next  = 1'b0;
        end

        unique case (cw.addr_op)
            tmcw_pkg::ADDR_ZERO: addr_next = '0;
            tmcw_pkg::ADDR_INC:  addr_next = addr_reg + tmcw_pkg::addr_t'(1);
            default:             addr_next = addr_reg;
        endcase

        unique case (cw.cur_op)
            tmcw_pkg::CUR_HOME:
            begin
                col_next = '0;
                row_next = '0;
            end
            tmcw_pkg::CUR_PUT:
            begin
                col_next    = tmcw_pkg::col_t'(put_col);
                row_next    = row_ovf ? tmcw_pkg::row_t'(tmcw_pkg::ROWS - 1)
                                      : tmcw_pkg::row_t'(put_row);
                scroll_next = row_ovf;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase

        unique case (cw.cond)
            tmcw_pkg::COND_DISPATCH:
                taken = (op_next == tmcw_pkg::OP_CLEAR);
            tmcw_pkg::COND_ROW_OVF:
                taken = row_ovf;
            tmcw_pkg::COND_NOT_LAST_CELL:
                taken = (addr_reg != tmcw_pkg::addr_t'(tmcw_pkg::CELL_COUNT - 1));
            tmcw_pkg::COND_NOT_COPY_END:
                taken = (addr_reg != tmcw_pkg::addr_t'(tmcw_pkg::COPY_COUNT - 1));
            default:
                taken = 1'b0;
        endcase

        // Idle holds until a start transaction arrives.
        if ((cw.cond == tmcw_pkg::COND_DISPATCH) && !accept)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = cw.fall;
            if (cw.report_on_fall && pending_reg)
            begin
                valid_next   = 1'b1;
                pending_next = 1'b0;
            end
        end
    end

    // Result capture from the cursor's next value
    always_comb
    begin
        loc_full  = tmcw_pkg::locx_t'(row_next) * tmcw_pkg::locx_t'(tmcw_pkg::COLUMNS)
                  + tmcw_pkg::locx_t'(col_next);
        loc_next  = valid_next ? tmcw_pkg::loc_out_t'(loc_full) : loc_reg;
        ccol_next = valid_next ? tmcw_pkg::col_out_t'(col_next) : ccol_reg;
        crow_next = valid_next ? tmcw_pkg::row_out_t'(row_next) : crow_reg;
        scr_next  = valid_next ? scroll_next : scr_reg;
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= tmcw_pkg::STEP_CLEAR_INIT;
            addr_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            scroll_reg  <= 1'b0;
            pending_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            addr_reg    <= addr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            scroll_reg  <= scroll_next;
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        char_reg <= char_next;
        attr_reg <= attr_next;
        loc_reg  <= loc_next;
        ccol_reg <= ccol_next;
        crow_reg <= crow_next;
        scr_reg  <= scr_next;
    end

    // Cell store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cw.mem_rd)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign valid           = valid_reg;
    assign cursor_location = loc_reg;
    assign cursor_column   = ccol_reg;
    assign cursor_row      = crow_reg;
    assign scrolled        = scr_reg;

    // Checks
    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= tmcw_pkg::col_t'(tmcw_pkg::COLUMNS - 1))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= tmcw_pkg::row_t'(tmcw_pkg::ROWS - 1))
        else $error("cursor row out of range");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && scrolled) |-> (cursor_row == tmcw_pkg::row_out_t'(tmcw_pkg::ROWS - 1)))
        else $error("scroll reported with cursor off the last row");

endmodule

`default_nettype wire

/* tb/text_mode_console_writer_checker.sv */
// Cursor predictor and result checker for the text console writer.
module text_mode_console_writer_checker
    import tmcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic [3:0]  background_color,
    input  logic [3:0]  foreground_color,
    input  logic        valid,
    input  logic [10:0] cursor_location,
    input  logic [6:0]  cursor_column,
    input  logic [4:0]  cursor_row,
    input  logic        scrolled,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked,
    output int          scrolls_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        loc_out_t location;
        col_out_t column;
        row_out_t row;
        logic     scrolled;
    } cursor_report_t;

    // Cell contents never reach the ports, so only the cursor is tracked.
    int             cursor_col;
    int             cursor_row_pos;
    cursor_report_t pending_cursor_q[$];
    cursor_report_t want;
    int             error_total;
    int             checked_total;
    int             scroll_total;

    function automatic cursor_report_t advance_cursor(logic op, logic [7:0] code);
        cursor_report_t r;
        int             c;
        int             rw;
        logic           scr;
        c   = cursor_col;
        rw  = cursor_row_pos;
        scr = 1'b0;
        if (op == OP_CLEAR)
        begin
            c  = 0;
            rw = 0;
        end
        else
        begin
            if (code == CHAR_BACKSPACE)
            begin
                if (c > 0)
                    c--;
            end
            else if (code == CHAR_TAB)
                c = (c / TAB_STOP + 1) * TAB_STOP;
            else if (code == CHAR_CR)
                c = 0;
            else if (code == CHAR_LF)
            begin
                c = 0;
                rw++;
            end
            else if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI)
                c++;
            if (c >= COLUMNS)
            begin
                c = 0;
                rw++;
            end
            if (rw >= ROWS)
            begin
                rw  = ROWS - 1;
                scr = 1'b1;
            end
        end
        cursor_col     = c;
        cursor_row_pos = rw;
        r.location     = loc_out_t'(rw * COLUMNS + c);
        r.column       = col_out_t'(c);
        r.row          = row_out_t'(rw);
        r.scrolled     = scr;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int want_val, int got_val);
        error_total++;
        if (error_total <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col     = 0;
            cursor_row_pos = 0;
            pending_cursor_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // Retire the result first: a new transaction may be taken at the same edge.
            if (valid)
            begin
                if (pending_cursor_q.size() == 0)
                    flag_mismatch("unexpected result, location", -1, cursor_location);
                else
                begin
                    want = pending_cursor_q.pop_front();
                    checked_total++;
                    if (scrolled)
                        scroll_total++;
                    if (cursor_location !== want.location)
                        flag_mismatch("cursor_location", want.location, cursor_location);
                    if (cursor_column !== want.column)
                        flag_mismatch("cursor_column", want.column, cursor_column);
                    if (cursor_row !== want.row)
                        flag_mismatch("cursor_row", want.row, cursor_row);
                    if (scrolled !== want.scrolled)
                        flag_mismatch("scrolled", want.scrolled, scrolled);
                end
            end
            if (start && !busy)
                pending_cursor_q.push_back(advance_cursor(operation, char_code));
            outstanding <= pending_cursor_q.size();
        end
        mismatches      <= error_total;
        results_checked <= checked_total;
        scrolls_seen    <= scroll_total;
    end

    initial
    begin
        error_total   = 0;
        checked_total = 0;
        scroll_total  = 0;
        mismatches    = 0;
        outstanding   = 0;
    end

endmodule

/* tb/text_mode_console_writer_tb.sv */
// Stimulus, watchdog and verdict for the text console writer.
module text_mode_console_writer_tb;
    import tmcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / 4;
    localparam int MAX_GAP        = 40;
    // A scroll and the reset clear each keep busy high while they walk the cell store.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 16;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        operation        = OP_PUT;
    logic [7:0]  char_code        = 8'h00;
    logic [3:0]  background_color = 4'h0;
    logic [3:0]  foreground_color = 4'h0;
    logic        busy;
    logic        valid;
    logic [10:0] cursor_location;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;

    int mismatches;
    int outstanding;
    int results_checked;
    int scrolls_seen;
    int idle_pct;
    int items_sent;
    int clears_sent;
    int quiet_cycles;

    always #6 clk = ~clk;

    text_mode_console_writer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .char_code        (char_code),
        .background_color (background_color),
        .foreground_color (foreground_color),
        .valid            (valid),
        .cursor_location  (cursor_location),
        .cursor_column    (cursor_column),
        .cursor_row       (cursor_row),
        .scrolled         (scrolled)
    );

    text_mode_console_writer_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .char_code        (char_code),
        .background_color (background_color),
        .foreground_color (foreground_color),
        .valid            (valid),
        .cursor_location  (cursor_location),
        .cursor_column    (cursor_column),
        .cursor_row       (cursor_row),
        .scrolled         (scrolled),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .results_checked  (results_checked),
        .scrolls_seen     (scrolls_seen)
    );

    // Present one transaction, hold it until busy drops, then idle for a
    // random number of cycles according to the current phase. With no gap,
    // start simply stays high for the next transaction.
    task automatic issue(input logic op, input logic [7:0] code,
                         input logic [3:0] bg, input logic [3:0] fg);
        int gap;
        gap = 0;
        start            <= 1'b1;
        operation        <= op;
        char_code        <= code;
        background_color <= bg;
        foreground_color <= fg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (op == OP_CLEAR)
            clears_sent++;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every pending cursor report has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic put_char(input logic [7:0] code, input logic [3:0] bg, input logic [3:0] fg);
        issue(OP_PUT, code, bg, fg);
    endtask

    // Bias toward printable text and line feeds so the cursor reaches the
    // bottom row and scrolls often; the rest is control codes and any byte.
    function automatic logic [7:0] random_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 52)
            return 8'($urandom_range(int'(CHAR_PRINT_HI), int'(CHAR_PRINT_LO)));
        else if (pick < 64)
            return CHAR_LF;
        else if (pick < 69)
            return CHAR_CR;
        else if (pick < 74)
            return CHAR_BACKSPACE;
        else if (pick < 80)
            return CHAR_TAB;
        return 8'($urandom);
    endfunction

    // Stop the run when nothing is accepted or reported for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
        items_sent   = 0;
        clears_sent  = 0;
        idle_pct     = 0;

        // Hold reset, then release it; the block clears its store before taking work.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clear with ignored fields at their extremes, backspace at
        // column zero, printable range ends with color extremes.
        issue(OP_CLEAR, 8'hFF, 4'hF, 4'hF);
        put_char(CHAR_BACKSPACE, 4'h0, 4'h0);
        put_char(CHAR_PRINT_LO, 4'h0, 4'h0);
        put_char(CHAR_PRINT_HI, 4'hF, 4'hF);
        put_char(CHAR_BACKSPACE, 4'hA, 4'h5);
        put_char(CHAR_TAB, 4'h5, 4'hA);
        put_char(CHAR_CR, 4'h3, 4'hC);
        // Codes that move nothing but still report the cursor.
        put_char(8'h00, 4'h1, 4'h2);
        put_char(8'h1F, 4'h2, 4'h1);
        put_char(8'h80, 4'h8, 4'h7);
        put_char(8'hFF, 4'h7, 4'h8);
        put_char(CHAR_LF, 4'h0, 4'hF);
        // Walk tab stops across the row; the last one overflows the column.
        repeat (COLUMNS / TAB_STOP) put_char(CHAR_TAB, 4'hF, 4'h0);
        issue(OP_CLEAR, 8'h41, 4'h0, 4'h0);

        // Random phases: no idling, heavy sender idling, no idling (the
        // receiver cannot stall), light idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 61;
                3:       idle_pct = 14;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off once mid-phase until the block has answered everything.
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(999) < 3)
                    issue(OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom));
                else
                    issue(OP_PUT, random_code(), 4'($urandom), 4'($urandom));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d clears); checked %0d cursor reports, %0d with scroll.",
                 items_sent, clears_sent, results_checked, scrolls_seen);
        $display("Mismatches: %0d, reports still pending: %0d.", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
